// ===== src/n_queens_solution_enumerator_core_assert.svh =====
// assertion macros for the n-queens enumerator core
// no dependencies; included by the top level only
`ifndef N_QUEENS_SOLUTION_ENUMERATOR_CORE_ASSERT_SVH
`define N_QUEENS_SOLUTION_ENUMERATOR_CORE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define NQSE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("nqse assertion failed");

// next-cycle implication, checked outside reset
`define NQSE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("nqse assertion failed");

`endif

// ===== src/nqse_pkg.sv =====
// shared types and constants for the n-queens enumerator
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package nqse_pkg;

    localparam int          MAX_BOARD_DEF  = 8;
    localparam int          BOARD_SIZE_W   = 4;
    localparam logic [3:0]  BOARD_SIZE_RST = 4'd8;
    localparam int          OUT_IDX_W      = 3;
    localparam int          SOL_W          = 16;
    localparam logic [15:0] SOL_MAX        = 16'hFFFF;
    localparam logic [2:0]  LAST_SHOWN     = 3'd7;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SELECT,
        ST_TRY,
        ST_EMIT,
        ST_EXHAUST
    } t_state;

    typedef struct packed {
        logic clear;
        logic clamp;
        logic load_row;
        logic inc_row;
        logic place;
        logic back_col;
        logic set_done;
        logic count_sol;
        logic emit;
        logic emit_exh;
    } t_dp_cmd;

    typedef struct packed {
        logic done;
        logic col_at_n;
        logic row_over;
        logic safe;
        logic col_zero;
        logic emit_last;
    } t_dp_status;

endpackage

`default_nettype wire

// ===== src/n_queens_solution_enumerator_core.sv =====
// sequence: accept in idle, then per search step a select state plus a try state for each
//   row tried, counting the row that runs past the board; results follow on consecutive cycles
// requests: one at a time; the conflict check tests one row per cycle
// reset: board size 8, empty board, solution count zero; results cannot be stalled
`timescale 1ns / 1ps
`default_nettype none

`include "n_queens_solution_enumerator_core_assert.svh"

module n_queens_solution_enumerator_core
    import nqse_pkg::*;
#(
    parameter int MaxBoard = MAX_BOARD_DEF
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    // request transaction
    input  wire logic                    start,
    output logic                         busy,
    input  wire logic                    i_restart,
    // board size register write
    input  wire logic                    i_cfg_wr_en,
    input  wire logic [BOARD_SIZE_W-1:0] i_cfg_board_size,
    // result transactions, one cycle each
    output logic                         o_valid,
    output logic [OUT_IDX_W-1:0]         o_column_index,
    output logic [OUT_IDX_W-1:0]         o_queen_row,
    output logic [SOL_W-1:0]             o_solution_number,
    output logic                         o_exhausted,
    output logic                         o_last
);

    t_dp_cmd    cmd;
    t_dp_status status;

    // controller walks select / try / emit / exhaust; only idle takes a new request
    nqse_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_restart (i_restart),
        .i_status  (status),
        .o_cmd     (cmd),
        .o_busy    (busy)
    );

    // datapath holds the board, the parallel conflict lanes and the result registers
    nqse_datapath #(
        .MaxBoard (MaxBoard)
    ) u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_wr_en       (i_cfg_wr_en),
        .i_cfg_board_size  (i_cfg_board_size),
        .i_cmd             (cmd),
        .o_status          (status),
        .o_valid           (o_valid),
        .o_column_index    (o_column_index),
        .o_queen_row       (o_queen_row),
        .o_solution_number (o_solution_number),
        .o_exhausted       (o_exhausted),
        .o_last            (o_last)
    );

    // an accepted request keeps the core busy until its results are out
    `NQSE_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy)
    // the final result of a request goes out as the core returns to idle
    `NQSE_ASSERT_NOW(a_last_idle, i_clk, i_rst_n, o_valid && o_last, !busy)
    // an exhausted result carries nothing else
    `NQSE_ASSERT_NOW(a_exh_clean, i_clk, i_rst_n, o_valid && o_exhausted,
        o_last && (o_column_index == '0) && (o_queen_row == '0) && (o_solution_number == '0))
    // a reported solution is always counted
    `NQSE_ASSERT_NOW(a_sol_nonzero, i_clk, i_rst_n, o_valid && !o_exhausted,
        o_solution_number != '0)

endmodule

`default_nettype wire

// ===== src/nqse_ctrl.sv =====
// search controller for the n-queens enumerator
// depends on nqse_pkg
`timescale 1ns / 1ps
`default_nettype none

module nqse_ctrl
    import nqse_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_start,
    input  wire logic       i_restart,
    input  wire t_dp_status i_status,
    output t_dp_cmd         o_cmd,
    output logic            o_busy
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_state = ST_SELECT;
                end
            end
            ST_SELECT: begin
                if (i_status.done) begin
                    n_state = ST_EXHAUST;
                end else if (i_status.col_at_n) begin
                    n_state = ST_EMIT;
                end else begin
                    n_state = ST_TRY;
                end
            end
            ST_TRY: begin
                if (i_status.row_over || i_status.safe) begin
                    n_state = ST_SELECT;
                end
            end
            ST_EMIT: begin
                if (i_status.emit_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_EXHAUST: n_state = ST_IDLE;
            default:    n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd  = '0;
        o_busy = (r_state != ST_IDLE);
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    o_cmd.clear = i_restart;
                    o_cmd.clamp = !i_restart;
                end
            end
            ST_SELECT: begin
                if (!i_status.done) begin
                    if (i_status.col_at_n) begin
                        o_cmd.count_sol = 1'b1;
                    end else begin
                        o_cmd.load_row = 1'b1;
                    end
                end
            end
            ST_TRY: begin
                if (i_status.row_over) begin
                    if (i_status.col_zero) begin
                        o_cmd.set_done = 1'b1;
                    end else begin
                        o_cmd.back_col = 1'b1;
                    end
                end else if (i_status.safe) begin
                    o_cmd.place = 1'b1;
                end else begin
                    o_cmd.inc_row = 1'b1;
                end
            end
            ST_EMIT:    o_cmd.emit     = 1'b1;
            ST_EXHAUST: o_cmd.emit_exh = 1'b1;
            default:    o_cmd          = '0;
        endcase
    end

endmodule

`default_nettype wire

// ===== src/nqse_datapath.sv =====
// board state, conflict check and result registers for the n-queens enumerator
// depends on nqse_pkg; driven by nqse_ctrl
`timescale 1ns / 1ps
`default_nettype none

module nqse_datapath
    import nqse_pkg::*;
#(
    parameter int MaxBoard = MAX_BOARD_DEF
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_cfg_wr_en,
    input  wire logic [BOARD_SIZE_W-1:0] i_cfg_board_size,
    input  wire t_dp_cmd                 i_cmd,
    output t_dp_status                   o_status,
    output logic                         o_valid,
    output logic [OUT_IDX_W-1:0]         o_column_index,
    output logic [OUT_IDX_W-1:0]         o_queen_row,
    output logic [SOL_W-1:0]             o_solution_number,
    output logic                         o_exhausted,
    output logic                         o_last
);

    localparam int CW = $clog2(MaxBoard + 1);
    localparam int IW = $clog2(MaxBoard);

    logic [BOARD_SIZE_W-1:0] r_board_size;
    logic [IW-1:0]           r_q [MaxBoard];
    logic [CW-1:0]           r_col;
    logic                    r_resume;
    logic [SOL_W-1:0]        r_sol;
    logic                    r_done;
    logic [CW-1:0]           r_row;
    logic [OUT_IDX_W-1:0]    r_k;

    logic                    r_valid;
    logic [OUT_IDX_W-1:0]    r_out_col;
    logic [OUT_IDX_W-1:0]    r_out_row;
    logic [SOL_W-1:0]        r_out_sol;
    logic                    r_out_exh;
    logic                    r_out_last;

    logic [CW-1:0]           side;
    logic [CW-1:0]           rd_addr;
    logic [IW-1:0]           rd_data;
    logic [OUT_IDX_W-1:0]    shown_m1;
    logic [MaxBoard-1:0]     hit;

    // clamp board size into 1..MaxBoard
    always_comb begin
        if (r_board_size == '0) begin
            side = CW'(1);
        end else if (int'(r_board_size) > MaxBoard) begin
            side = CW'(MaxBoard);
        end else begin
            side = CW'(r_board_size);
        end
    end

    // single read port: current column while searching, output column while emitting
    assign rd_addr = i_cmd.emit ? CW'(r_k) : r_col;
    assign rd_data = (int'(rd_addr) < MaxBoard) ? r_q[rd_addr[IW-1:0]] : '0;

    assign shown_m1 = (int'(side) >= 8) ? LAST_SHOWN : OUT_IDX_W'(side - CW'(1));

    // one comparator lane per earlier column
    for (genvar i = 0; i < MaxBoard; i++) begin : g_lane
        logic [CW:0] q_ext;
        logic [CW:0] r_ext;
        logic [CW:0] diff;
        logic [CW:0] span;
        assign q_ext = {{(CW + 1 - IW){1'b0}}, r_q[i]};
        assign r_ext = {1'b0, r_row};
        assign diff  = (q_ext > r_ext) ? (q_ext - r_ext) : (r_ext - q_ext);
        assign span  = {1'b0, r_col} - (CW + 1)'(i);
        assign hit[i] = (int'(r_col) > i) && ((q_ext == r_ext) || (diff == span));
    end

    assign o_status.done      = r_done;
    assign o_status.col_at_n  = (r_col == side);
    assign o_status.row_over  = (r_row >= side);
    assign o_status.safe      = ~|hit;
    assign o_status.col_zero  = (r_col == '0);
    assign o_status.emit_last = (r_k == shown_m1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_board_size <= BOARD_SIZE_RST;
            r_col        <= '0;
            r_resume     <= 1'b0;
            r_sol        <= '0;
            r_done       <= 1'b0;
            r_k          <= '0;
            r_valid      <= 1'b0;
        end else begin
            r_valid <= i_cmd.emit | i_cmd.emit_exh;
            if (i_cfg_wr_en || i_cmd.clear) begin
                if (i_cfg_wr_en) begin
                    r_board_size <= i_cfg_board_size;
                end
                r_col    <= '0;
                r_resume <= 1'b0;
                r_sol    <= '0;
                r_done   <= 1'b0;
                r_k      <= '0;
            end else begin
                if (i_cmd.clamp && (r_col >= side)) begin
                    r_col <= side - CW'(1);
                end
                if (i_cmd.load_row) begin
                    r_resume <= 1'b0;
                end
                if (i_cmd.place) begin
                    r_col <= r_col + CW'(1);
                end
                if (i_cmd.back_col) begin
                    r_col    <= r_col - CW'(1);
                    r_resume <= 1'b1;
                end
                if (i_cmd.set_done) begin
                    r_done <= 1'b1;
                end
                if (i_cmd.count_sol && (r_sol != SOL_MAX)) begin
                    r_sol <= r_sol + SOL_W'(1);
                end
                if (i_cmd.emit) begin
                    if (o_status.emit_last) begin
                        // next request resumes in the last column
                        r_k      <= '0;
                        r_col    <= side - CW'(1);
                        r_resume <= 1'b1;
                    end else begin
                        r_k <= r_k + OUT_IDX_W'(1);
                    end
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_row) begin
            r_row <= r_resume ? (CW'(rd_data) + CW'(1)) : '0;
        end else if (i_cmd.inc_row) begin
            r_row <= r_row + CW'(1);
        end
        if (i_cmd.place) begin
            r_q[r_col[IW-1:0]] <= r_row[IW-1:0];
        end
        if (i_cmd.emit) begin
            r_out_col  <= r_k;
            r_out_row  <= OUT_IDX_W'(rd_data);
            r_out_sol  <= r_sol;
            r_out_exh  <= 1'b0;
            r_out_last <= o_status.emit_last;
        end else if (i_cmd.emit_exh) begin
            r_out_col  <= '0;
            r_out_row  <= '0;
            r_out_sol  <= '0;
            r_out_exh  <= 1'b1;
            r_out_last <= 1'b1;
        end
    end

    assign o_valid           = r_valid;
    assign o_column_index    = r_out_col;
    assign o_queen_row       = r_out_row;
    assign o_solution_number = r_out_sol;
    assign o_exhausted       = r_out_exh;
    assign o_last            = r_out_last;

endmodule

`default_nettype wire
